### hw/rtl/date_time_to_epoch_ns_assert.svh
// Assertion macros for the date-time to epoch nanoseconds block.
`ifndef DATE_TIME_TO_EPOCH_NS_ASSERT_SVH
`define DATE_TIME_TO_EPOCH_NS_ASSERT_SVH
`ifndef SYNTH
`define DTEN_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("date_time_to_epoch_ns: same-cycle check failed");
`define DTEN_ASSERT_NXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("date_time_to_epoch_ns: next-cycle check failed");
`else
`define DTEN_ASSERT_IMP(label, clk, rst, ante, cons)
`define DTEN_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

### hw/rtl/dten_pkg.sv
// Types, constants and calendar tables shared by the epoch conversion block.
package dten_pkg;

  localparam int unsigned YEAR_W     = 13;
  localparam int unsigned DOY_W      = 9;
  localparam int unsigned MON_W      = 4;
  localparam int unsigned MDAY_W     = 5;
  localparam int unsigned HOUR_W     = 5;
  localparam int unsigned MIN_W      = 6;
  localparam int unsigned SEC_W      = 6;
  localparam int unsigned NSEC_W     = 30;
  localparam int unsigned IN_DATA_W  = 80;
  localparam int unsigned OUT_DATA_W = 64;
  localparam int unsigned STATUS_W   = 2;

  localparam int unsigned Q4_W        = YEAR_W - 2;
  localparam int unsigned RECIP_W     = 11;
  localparam int unsigned RECIP_SHIFT = 15;
  localparam int unsigned Q100_W      = Q4_W + RECIP_W - RECIP_SHIFT;
  localparam int unsigned LC_W        = 11;
  localparam int unsigned TOD_W       = 17;
  localparam int unsigned DAYS_W      = 22;
  localparam int unsigned SECS_W      = 38;
  localparam int unsigned SPLIT       = 20;
  localparam int unsigned PLO_W       = SPLIT + NSEC_W;
  localparam int unsigned PHI_W       = SECS_W - SPLIT + NSEC_W + 1;
  localparam int unsigned SUM_W       = 70;

  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 13'd1800;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 13'd5000;
  localparam logic [HOUR_W-1:0]  HOUR_MAX   = 5'd23;
  localparam logic [MIN_W-1:0]   MINUTE_MAX = 6'd59;
  localparam logic [SEC_W-1:0]   SECOND_MAX = 6'd60;
  localparam logic [NSEC_W-1:0]  NS_MAX     = 30'd999999999;
  localparam logic [NSEC_W-1:0]  NS_PER_SEC = 30'd1000000000;
  localparam logic [RECIP_W-1:0] RECIP_25   = 11'd1311;

  localparam logic [TOD_W-1:0] SEC_PER_HOUR = 17'd3600;
  localparam logic [TOD_W-1:0] SEC_PER_MIN  = 17'd60;
  localparam logic [TOD_W-1:0] SEC_PER_DAY  = 17'd86400;

  localparam logic [DOY_W-1:0] DAYS_YEAR      = 9'd365;
  localparam logic [DOY_W-1:0] DAYS_LEAP_YEAR = 9'd366;
  localparam int unsigned      EPOCH_YEAR     = 1970;
  localparam int unsigned      LEAPS_BEFORE_EPOCH = 477;
  localparam int unsigned      DAY_BIAS       = LEAPS_BEFORE_EPOCH + 1;
  localparam logic [Q100_W-1:0] CENTURY_DIV   = 7'd25;

  localparam logic signed [SECS_W-1:0] SECS_NEG_LIMIT = -38'sd9223372036;

  localparam logic [MON_W-1:0] JANUARY  = 4'd1;
  localparam logic [MON_W-1:0] FEBRUARY = 4'd2;
  localparam logic [MON_W-1:0] DECEMBER = 4'd12;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK       = 2'd0,
    STATUS_RANGE    = 2'd1,
    STATUS_OVERFLOW = 2'd2
  } status_t;

  typedef struct packed {
    logic              req;
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [MON_W-1:0]  month;
    logic [MDAY_W-1:0] mday;
    logic [TOD_W-1:0]  tod;
    logic [NSEC_W-1:0] nsec;
    logic              range_bad;
    logic [Q4_W-1:0]   q4y;
    logic [Q100_W-1:0] q100y;
    logic [Q4_W-1:0]   q4n;
    logic [Q100_W-1:0] q100n;
  } s1_t;

  typedef struct packed {
    logic              ok;
    logic [YEAR_W-1:0] year;
    logic [LC_W-1:0]   lc;
    logic [DOY_W-1:0]  yday;
    logic [TOD_W-1:0]  tod;
    logic [NSEC_W-1:0] nsec;
  } s2_t;

  typedef struct packed {
    logic              ok;
    logic [DAYS_W-1:0] days;
    logic [TOD_W-1:0]  tod;
    logic [NSEC_W-1:0] nsec;
  } s3_t;

  typedef struct packed {
    logic              ok;
    logic [SECS_W-1:0] secs;
    logic [NSEC_W-1:0] nsec;
  } s4_t;

  typedef struct packed {
    logic              ok;
    logic              neg_ovf;
    logic [NSEC_W-1:0] nsec;
  } s5_t;

  // Quotient by 25 through a scaled reciprocal; exact for all 11-bit inputs.
  function automatic logic [Q100_W-1:0] div25(input logic [Q4_W-1:0] x);
    logic [Q4_W+RECIP_W-1:0] p;
    p = (Q4_W+RECIP_W)'(x) * (Q4_W+RECIP_W)'(RECIP_25);
    return p[Q4_W+RECIP_W-1:RECIP_SHIFT];
  endfunction

  function automatic logic [DOY_W-1:0] days_before_month(input logic [MON_W-1:0] m);
    logic [DOY_W-1:0] d;
    unique case (m)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  function automatic logic [MDAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
    logic [MDAY_W-1:0] n;
    unique case (m) inside
      4'd2:                    n = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: n = 5'd30;
      default:                 n = 5'd31;
    endcase
    return n;
  endfunction

endpackage

### hw/rtl/dten_nsmul.sv
// Seconds to nanoseconds scaling as two registered partial products.
module dten_nsmul (
  input  logic                          clk,
  input  logic                          load,
  input  logic [dten_pkg::SECS_W-1:0]   secs,
  output logic [dten_pkg::PLO_W-1:0]    p_lo,
  output logic [dten_pkg::PHI_W-1:0]    p_hi
);

  localparam int unsigned HI_W = dten_pkg::SECS_W - dten_pkg::SPLIT;

  logic [dten_pkg::PHI_W-1:0] hi_ext;
  logic [dten_pkg::PLO_W-1:0] p_lo_next;
  logic [dten_pkg::PHI_W-1:0] p_hi_next;

  always_comb begin
    hi_ext    = {{(dten_pkg::PHI_W-HI_W){secs[dten_pkg::SECS_W-1]}},
                 secs[dten_pkg::SECS_W-1:dten_pkg::SPLIT]};
    p_lo_next = dten_pkg::PLO_W'(secs[dten_pkg::SPLIT-1:0])
              * dten_pkg::PLO_W'(dten_pkg::NS_PER_SEC);
    p_hi_next = hi_ext * dten_pkg::PHI_W'(dten_pkg::NS_PER_SEC);
  end

  always_ff @(posedge clk) begin
    if (load) begin
      p_lo <= p_lo_next;
      p_hi <= p_hi_next;
    end
  end

endmodule

### hw/rtl/date_time_to_epoch_ns.sv
// Top level of the calendar date-time to Unix epoch nanoseconds converter.
// The slave stream carries one UTC date-time per transaction: tuser selects
// year plus day of year (0) or year, month and day of month (1), and tdata
// holds the date and time-of-day fields. The master stream returns one
// transaction per input: tdata is the signed count of nanoseconds since
// 1970-01-01, tuser the status (ok, field out of range, or overflow).
// Invalid or overflowing inputs return zero in tdata.
// The block is a six-stage pipeline: calendar decode, leap and day-of-year
// resolution, day count, seconds, partial products of the nanosecond scale,
// and the final sum with overflow check in the output register. One
// transaction is accepted per cycle unless back-pressure from the receiver
// has filled every stage. The nanosecond scaling multiplier pair sets the stage depth.
// Each stage holds its content while the next is full, so a stalled
// receiver only blocks the input once every stage is occupied; bubbles are
// squeezed out. Reset clears all stage valid flags.
`include "date_time_to_epoch_ns_assert.svh"
module date_time_to_epoch_ns (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // year, day_of_year, month, month_day, hour, minute, second, nanosecond
  input  logic [79:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_ns
  output logic [63:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser
);

  localparam int unsigned NSTAGE = 6;

  logic [NSTAGE-1:0] valid;
  logic [NSTAGE-1:0] adv;
  logic [NSTAGE-1:0] valid_in;

  dten_pkg::s1_t s1, s1_next;
  dten_pkg::s2_t s2, s2_next;
  dten_pkg::s3_t s3, s3_next;
  dten_pkg::s4_t s4, s4_next;
  dten_pkg::s5_t s5, s5_next;

  logic [dten_pkg::YEAR_W-1:0] yr, yr_m1;
  logic [dten_pkg::HOUR_W-1:0] hour;
  logic [dten_pkg::MIN_W-1:0]  minute;
  logic [dten_pkg::SEC_W-1:0]  sec;

  logic                         leap, century, mon_ok, day_ok;
  logic [dten_pkg::MDAY_W-1:0]  mlen;
  logic [dten_pkg::DOY_W-1:0]   yday_md, doy_max;
  logic [dten_pkg::SECS_W-1:0]  days_ext;

  logic [dten_pkg::PLO_W-1:0]   p_lo;
  logic [dten_pkg::PHI_W-1:0]   p_hi;
  logic [dten_pkg::SUM_W-1:0]   hi_ext, total;
  logic                         ovf;
  logic [dten_pkg::OUT_DATA_W-1:0] epoch_next;
  logic [dten_pkg::STATUS_W-1:0]   status_next;

  always_comb begin
    adv[NSTAGE-1] = !valid[NSTAGE-1] || m_axis_tready;
    for (int k = NSTAGE - 2; k >= 0; k--) begin
      adv[k] = !valid[k] || adv[k+1];
    end
    valid_in = {valid[NSTAGE-2:0], s_axis_tvalid};
  end

  assign s_axis_tready = adv[0];
  assign m_axis_tvalid = valid[NSTAGE-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      for (int k = 0; k < NSTAGE; k++) begin
        if (adv[k]) begin
          valid[k] <= valid_in[k];
        end
      end
    end
  end

  // Stage 1: field unpack, range checks, century quotients, time of day.
  always_comb begin
    yr     = s_axis_tdata[12:0];
    yr_m1  = yr - 13'd1;
    hour   = s_axis_tdata[35:31];
    minute = s_axis_tdata[41:36];
    sec    = s_axis_tdata[47:42];

    s1_next.req   = s_axis_tuser[0];
    s1_next.year  = yr;
    s1_next.doy   = s_axis_tdata[21:13];
    s1_next.month = s_axis_tdata[25:22];
    s1_next.mday  = s_axis_tdata[30:26];
    s1_next.nsec  = s_axis_tdata[77:48];
    s1_next.tod   = dten_pkg::TOD_W'(hour) * dten_pkg::SEC_PER_HOUR
                  + dten_pkg::TOD_W'(minute) * dten_pkg::SEC_PER_MIN
                  + dten_pkg::TOD_W'(sec);
    s1_next.range_bad = (yr < dten_pkg::YEAR_MIN) || (yr > dten_pkg::YEAR_MAX)
                     || (hour > dten_pkg::HOUR_MAX) || (minute > dten_pkg::MINUTE_MAX)
                     || (sec > dten_pkg::SECOND_MAX)
                     || (s_axis_tdata[77:48] > dten_pkg::NS_MAX);
    s1_next.q4y   = yr[dten_pkg::YEAR_W-1:2];
    s1_next.q100y = dten_pkg::div25(yr[dten_pkg::YEAR_W-1:2]);
    s1_next.q4n   = yr_m1[dten_pkg::YEAR_W-1:2];
    s1_next.q100n = dten_pkg::div25(yr_m1[dten_pkg::YEAR_W-1:2]);
  end

  // Stage 2: leap year, leap days before the year, day of year and validity.
  always_comb begin
    century = (s1.q4y == dten_pkg::Q4_W'(s1.q100y) * dten_pkg::Q4_W'(dten_pkg::CENTURY_DIV));
    leap    = (s1.year[1:0] == 2'd0) && (!century || (s1.q100y[1:0] == 2'd0));
    mon_ok  = (s1.month >= dten_pkg::JANUARY) && (s1.month <= dten_pkg::DECEMBER);
    mlen    = dten_pkg::month_len(s1.month, leap);
    yday_md = dten_pkg::days_before_month(s1.month)
            + dten_pkg::DOY_W'(leap && (s1.month > dten_pkg::FEBRUARY))
            + dten_pkg::DOY_W'(s1.mday);
    doy_max = leap ? dten_pkg::DAYS_LEAP_YEAR : dten_pkg::DAYS_YEAR;
    if (s1.req) begin
      day_ok = mon_ok && (s1.mday <= mlen);
    end else begin
      day_ok = (s1.doy != '0) && (s1.doy <= doy_max);
    end

    s2_next.ok   = !s1.range_bad && day_ok;
    s2_next.year = s1.year;
    s2_next.lc   = dten_pkg::LC_W'(s1.q4n) - dten_pkg::LC_W'(s1.q100n)
                 + dten_pkg::LC_W'(s1.q100n[dten_pkg::Q100_W-1:2]);
    s2_next.yday = s1.req ? yday_md : s1.doy;
    s2_next.tod  = s1.tod;
    s2_next.nsec = s1.nsec;
  end

  // Stage 3: days since the epoch.
  always_comb begin
    s3_next.ok   = s2.ok;
    s3_next.days = (dten_pkg::DAYS_W'(s2.year) - dten_pkg::DAYS_W'(dten_pkg::EPOCH_YEAR))
                 * dten_pkg::DAYS_W'(dten_pkg::DAYS_YEAR)
                 + dten_pkg::DAYS_W'(s2.lc) + dten_pkg::DAYS_W'(s2.yday)
                 - dten_pkg::DAYS_W'(dten_pkg::DAY_BIAS);
    s3_next.tod  = s2.tod;
    s3_next.nsec = s2.nsec;
  end

  // Stage 4: seconds since the epoch.
  always_comb begin
    days_ext = {{(dten_pkg::SECS_W-dten_pkg::DAYS_W){s3.days[dten_pkg::DAYS_W-1]}},
                s3.days};
    s4_next.ok   = s3.ok;
    s4_next.secs = days_ext * dten_pkg::SECS_W'(dten_pkg::SEC_PER_DAY)
                 + dten_pkg::SECS_W'(s3.tod);
    s4_next.nsec = s3.nsec;
  end

  // Stage 5: partial products, plus the lower bound check on the seconds.
  always_comb begin
    s5_next.ok      = s4.ok;
    s5_next.neg_ovf = $signed(s4.secs) < dten_pkg::SECS_NEG_LIMIT;
    s5_next.nsec    = s4.nsec;
  end

  dten_nsmul u_nsmul (
    .clk  (clk),
    .load (adv[4]),
    .secs (s4.secs),
    .p_lo (p_lo),
    .p_hi (p_hi)
  );

  // Stage 6: final sum and the signed 64-bit range check.
  always_comb begin
    hi_ext = {{(dten_pkg::SUM_W-dten_pkg::PHI_W-dten_pkg::SPLIT){p_hi[dten_pkg::PHI_W-1]}},
              p_hi, {dten_pkg::SPLIT{1'b0}}};
    total  = hi_ext + dten_pkg::SUM_W'(p_lo) + dten_pkg::SUM_W'(s5.nsec);
    ovf    = s5.neg_ovf
          || !((total[dten_pkg::SUM_W-1:dten_pkg::OUT_DATA_W-1] == '0)
            || (total[dten_pkg::SUM_W-1:dten_pkg::OUT_DATA_W-1] == '1));
    if (!s5.ok) begin
      status_next = dten_pkg::STATUS_RANGE;
      epoch_next  = '0;
    end else if (ovf) begin
      status_next = dten_pkg::STATUS_OVERFLOW;
      epoch_next  = '0;
    end else begin
      status_next = dten_pkg::STATUS_OK;
      epoch_next  = total[dten_pkg::OUT_DATA_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      s1 <= s1_next;
    end
    if (adv[1]) begin
      s2 <= s2_next;
    end
    if (adv[2]) begin
      s3 <= s3_next;
    end
    if (adv[3]) begin
      s4 <= s4_next;
    end
    if (adv[4]) begin
      s5 <= s5_next;
    end
    if (adv[5]) begin
      m_axis_tdata <= epoch_next;
      m_axis_tuser <= status_next;
    end
  end

  `DTEN_ASSERT_IMP(a_error_zero, clk, rst, m_axis_tvalid && (m_axis_tuser != dten_pkg::STATUS_OK), m_axis_tdata == '0)
  `DTEN_ASSERT_NXT(a_accept_enters, clk, rst, s_axis_tvalid && s_axis_tready, valid[0])
  `DTEN_ASSERT_IMP(a_full_blocks, clk, rst, (&valid) && !m_axis_tready, !s_axis_tready)

endmodule

### tb/epoch_ns_checker.sv
`timescale 1ns / 1ps
// Checker that predicts and compares every epoch conversion on both streams.
module epoch_ns_checker
  import dten_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  input  logic        s_axis_tready,
  // year, day_of_year, month, month_day, hour, minute, second, nanosecond
  input  logic [79:0] s_axis_tdata,
  // req_type
  input  logic [0:0]  s_axis_tuser,
  input  logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // epoch_ns
  input  logic [63:0] m_axis_tdata,
  // status
  input  logic [1:0]  m_axis_tuser,
  output int          error_count,
  output int          pending
);

  localparam longint NS_SCALE  = 1000000000;
  localparam longint INT64_TOP = 64'sh7fff_ffff_ffff_ffff;
  localparam longint INT64_BOT = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] epoch_ns;
    status_t     status;
  } epoch_result_t;

  epoch_result_t expected_epochs[$];

  initial begin
    error_count = 0;
    pending = 0;
  end

  function automatic longint days_in_month(input longint m, input bit leap);
    case (m) inside
      2:              return leap ? 29 : 28;
      4, 6, 9, 11:    return 30;
      default:        return 31;
    endcase
  endfunction

  function automatic epoch_result_t predict_epoch(input logic [79:0] fields, input logic by_month);
    epoch_result_t res;
    longint yr, yday, mon, mday, hr, mi, sc, ns, days, secs;
    bit leap;
    bit fields_ok;
    yr   = longint'(fields[12:0]);
    yday = longint'(fields[21:13]);
    mon  = longint'(fields[25:22]);
    mday = longint'(fields[30:26]);
    hr   = longint'(fields[35:31]);
    mi   = longint'(fields[41:36]);
    sc   = longint'(fields[47:42]);
    ns   = longint'(fields[77:48]);
    res.epoch_ns = '0;
    res.status = STATUS_RANGE;
    if (yr < 1800 || yr > 5000) return res;
    leap = ((yr % 4 == 0) && (yr % 100 != 0)) || (yr % 400 == 0);
    fields_ok = 1'b1;
    if (!by_month) begin
      if (yday < 1 || yday > (leap ? 366 : 365)) fields_ok = 1'b0;
    end else if (mon < 1 || mon > 12) begin
      fields_ok = 1'b0;
    end else if (mday > days_in_month(mon, leap)) begin
      fields_ok = 1'b0;
    end else begin
      yday = mday;
      for (longint k = 1; k < mon; k++) yday += days_in_month(k, leap);
    end
    if (hr > 23 || mi > 59 || sc > 60 || ns > 999999999) fields_ok = 1'b0;
    if (!fields_ok) return res;
    days = 365 * (yr - 1970)
         + ((yr - 1) / 4 - (yr - 1) / 100 + (yr - 1) / 400 - 477)
         + yday - 1;
    secs = ((days * 24 + hr) * 60 + mi) * 60 + sc;
    if (secs > (INT64_TOP - ns) / NS_SCALE || secs < INT64_BOT / NS_SCALE) begin
      res.status = STATUS_OVERFLOW;
      return res;
    end
    res.epoch_ns = secs * NS_SCALE + ns;
    res.status = STATUS_OK;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("%0t: %s wrong: got %0h, expected %0h", $time, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin
    epoch_result_t want;
    if (rst) begin
      expected_epochs.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_epochs.size() == 0) begin
          report_mismatch("unexpected transaction", m_axis_tdata, '0);
        end else begin
          want = expected_epochs.pop_front();
          if (m_axis_tdata !== want.epoch_ns)
            report_mismatch("epoch_ns", m_axis_tdata, want.epoch_ns);
          if (m_axis_tuser !== want.status)
            report_mismatch("status", 64'(m_axis_tuser), 64'(want.status));
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_epochs.push_back(predict_epoch(s_axis_tdata, s_axis_tuser[0]));
    end
    pending = expected_epochs.size();
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench: clock, reset, date-time stimulus and the verdict.
module testbench;
  import dten_pkg::*;

  localparam int ITEMS_PER_PHASE = 475;
  localparam int CYCLE_LIMIT     = 400000;
  localparam int SETTLE_CYCLES   = 16;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic [0:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [63:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int cycles = 0;
  int errors;
  int pending;

  date_time_to_epoch_ns i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  epoch_ns_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .error_count   (errors),
    .pending       (pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(negedge clk) begin
    m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic send_date_time(input logic req, input logic [YEAR_W-1:0] year,
                                input logic [DOY_W-1:0] doy, input logic [MON_W-1:0] month,
                                input logic [MDAY_W-1:0] mday, input logic [HOUR_W-1:0] hour,
                                input logic [MIN_W-1:0] minute, input logic [SEC_W-1:0] second,
                                input logic [NSEC_W-1:0] nsec);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= req;
    s_axis_tdata  <= {2'b00, nsec, second, minute, hour, mday, month, doy, year};
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic send_random_date_time();
    int pick;
    logic              req;
    logic [YEAR_W-1:0] year;
    logic [DOY_W-1:0]  doy;
    logic [MON_W-1:0]  month;
    logic [MDAY_W-1:0] mday;
    logic [HOUR_W-1:0] hour;
    logic [MIN_W-1:0]  minute;
    logic [SEC_W-1:0]  second;
    logic [NSEC_W-1:0] nsec;
    pick   = int'($urandom_range(99));
    req    = 1'($urandom_range(1));
    year   = YEAR_W'(($urandom_range(9) < 7) ? $urandom_range(1800, 2262)
                                             : $urandom_range(1800, 5000));
    doy    = ($urandom_range(19) == 0) ? 9'd366 : DOY_W'($urandom_range(1, 365));
    month  = MON_W'($urandom_range(1, 12));
    mday   = MDAY_W'(($urandom_range(7) == 0) ? $urandom_range(29, 31)
                                              : $urandom_range(0, 28));
    hour   = HOUR_W'($urandom_range(0, 23));
    minute = MIN_W'($urandom_range(0, 59));
    second = ($urandom_range(19) == 0) ? 6'd60 : SEC_W'($urandom_range(0, 59));
    nsec   = NSEC_W'($urandom_range(0, 999999999));
    if (req) begin
      doy = DOY_W'($urandom_range(0, 511));
    end else begin
      month = MON_W'($urandom_range(0, 15));
      mday  = MDAY_W'($urandom_range(0, 31));
    end
    if (pick >= 80 && pick < 92) begin
      case ($urandom_range(6))
        0: year = YEAR_W'($urandom_range(0, 8191));
        1: doy = DOY_W'($urandom_range(0, 511));
        2: month = MON_W'($urandom_range(0, 15));
        3: mday = MDAY_W'($urandom_range(0, 31));
        4: hour = HOUR_W'($urandom_range(0, 31));
        5: minute = MIN_W'($urandom_range(0, 63));
        default: begin
          second = SEC_W'($urandom_range(0, 63));
          nsec = NSEC_W'($urandom_range(0, 1073741823));
        end
      endcase
    end else if (pick >= 92) begin
      year   = YEAR_W'($urandom_range(0, 8191));
      doy    = DOY_W'($urandom_range(0, 511));
      month  = MON_W'($urandom_range(0, 15));
      mday   = MDAY_W'($urandom_range(0, 31));
      hour   = HOUR_W'($urandom_range(0, 31));
      minute = MIN_W'($urandom_range(0, 63));
      second = SEC_W'($urandom_range(0, 63));
      nsec   = NSEC_W'($urandom_range(0, 1073741823));
    end
    send_date_time(req, year, doy, month, mday, hour, minute, second, nsec);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    tx_idle_pct  = 9;
    rx_stall_pct = 83;

    send_date_time(1'b0, 13'd1970, 9'd1, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd1969, 9'd365, 4'd0, 5'd0, 5'd23, 6'd59, 6'd59, 30'd999999999);
    send_date_time(1'b0, 13'd1800, 9'd1, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd1799, 9'd365, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd5000, 9'd365, 4'd0, 5'd0, 5'd23, 6'd59, 6'd60, 30'd999999999);
    send_date_time(1'b0, 13'd5000, 9'd366, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd5001, 9'd1, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd0, 9'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd8191, 9'd1, 4'd1, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd2000, 9'd366, 4'd15, 5'd31, 5'd12, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd1900, 9'd366, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd2024, 9'd0, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd2023, 9'd511, 4'd2, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd2000, 9'd511, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd1900, 9'd60, 4'd2, 5'd29, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd2023, 9'd0, 4'd1, 5'd0, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd2024, 9'd0, 4'd3, 5'd0, 5'd6, 6'd30, 6'd15, 30'd500);
    send_date_time(1'b1, 13'd2023, 9'd0, 4'd12, 5'd31, 5'd23, 6'd59, 6'd60, 30'd0);
    send_date_time(1'b1, 13'd2023, 9'd0, 4'd0, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd2023, 9'd0, 4'd13, 5'd1, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b1, 13'd2023, 9'd0, 4'd4, 5'd31, 5'd0, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd2023, 9'd100, 4'd0, 5'd0, 5'd24, 6'd0, 6'd0, 30'd0);
    send_date_time(1'b0, 13'd2023, 9'd100, 4'd0, 5'd0, 5'd0, 6'd60, 6'd61, 30'd0);
    send_date_time(1'b0, 13'd2023, 9'd100, 4'd0, 5'd0, 5'd31, 6'd63, 6'd63,
                   30'd1073741823);
    send_date_time(1'b0, 13'd2023, 9'd100, 4'd0, 5'd0, 5'd0, 6'd0, 6'd0, 30'd1000000000);
    send_date_time(1'b1, 13'd2262, 9'd0, 4'd4, 5'd11, 5'd23, 6'd47, 6'd16, 30'd854775807);
    send_date_time(1'b1, 13'd2262, 9'd0, 4'd4, 5'd11, 5'd23, 6'd47, 6'd16, 30'd854775808);

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin
          tx_idle_pct  = 9;
          rx_stall_pct = 83;
        end
        1: begin
          tx_idle_pct  = 83;
          rx_stall_pct = 9;
        end
        default: begin
          tx_idle_pct  = 0;
          rx_stall_pct = 0;
        end
      endcase
      for (int n = 0; n < ITEMS_PER_PHASE; n++) send_random_date_time();
      s_axis_tvalid <= 1'b0;
      @(negedge clk);
      while (pending != 0) @(negedge clk);
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
